/* rtl/alt_pkg.sv */
// Shared types and codes for the alarm lifecycle table.
// Used by the front, the back, the top level and the checker; no dependencies.
package alt_pkg;

  // Table size defaults.
  localparam int DEF_TABLE_DEPTH = 32;
  localparam int DEF_CODE_BITS   = 16;

  // Stream payload widths, padded to whole bytes.
  localparam int IN_BITS  = 56;
  localparam int OUT_BITS = 56;

  // Action codes on the input stream.
  localparam logic [2:0] ACTION_RAISE        = 3'd0;
  localparam logic [2:0] ACTION_CLEAR        = 3'd1;
  localparam logic [2:0] ACTION_CLEAR_ACTIVE = 3'd2;
  localparam logic [2:0] ACTION_ACK          = 3'd3;
  localparam logic [2:0] ACTION_ACK_ALL      = 3'd4;

  // Result status codes.
  localparam logic [2:0] ST_NEW       = 3'd0;
  localparam logic [2:0] ST_EVICTED   = 3'd1;
  localparam logic [2:0] ST_REACTIVE  = 3'd2;
  localparam logic [2:0] ST_REFRESH   = 3'd3;
  localparam logic [2:0] ST_REJECTED  = 3'd4;
  localparam logic [2:0] ST_NOT_FOUND = 3'd5;
  localparam logic [2:0] ST_ALREADY   = 3'd6;
  localparam logic [2:0] ST_APPLIED   = 3'd7;

  // Entry lifecycle.
  typedef enum logic [1:0] {
    LC_ACTIVE  = 2'd0,
    LC_ACKED   = 2'd1,
    LC_CLEARED = 2'd2
  } lc_t;

  // Operation as classified by the front.
  typedef enum logic [2:0] {
    OP_RAISE,
    OP_CLEAR,
    OP_CLEAR_ACTIVE,
    OP_ACK,
    OP_ACK_ALL,
    OP_LOOKUP
  } op_t;

  // One queued request.
  typedef struct packed {
    op_t         op;
    logic [15:0] code;
    logic [2:0]  sev;
    logic [31:0] now;
  } item_t;

  // One result, last field in the lowest bits.
  typedef struct packed {
    logic        dirty;
    logic [31:0] overflow_total;
    logic [2:0]  highest_severity;
    logic [5:0]  total_count;
    logic [5:0]  active_count;
    logic [4:0]  slot;
    logic [2:0]  status;
  } result_t;

endpackage

/* rtl/alt_front.sv */
// Front of the alarm table: accepts requests, classifies the action and
// queues them in a two-entry queue. Depends on alt_pkg.
module alt_front
  import alt_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [IN_BITS-1:0] s_tdata,  // action[2:0], alarm_code[18:3], severity[21:19],
                                       // now_time[53:22], zero pad
  output logic               q_valid,
  output item_t              q_item,
  input  logic               q_pop
);

  item_t      fifo [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       push;
  item_t      item_in;

  // Classify the incoming action.
  always_comb begin
    item_in.code = s_tdata[18:3];
    item_in.sev  = s_tdata[21:19];
    item_in.now  = s_tdata[53:22];
    unique case (s_tdata[2:0])
      ACTION_RAISE:        item_in.op = OP_RAISE;
      ACTION_CLEAR:        item_in.op = OP_CLEAR;
      ACTION_CLEAR_ACTIVE: item_in.op = OP_CLEAR_ACTIVE;
      ACTION_ACK:          item_in.op = OP_ACK;
      ACTION_ACK_ALL:      item_in.op = OP_ACK_ALL;
      default:             item_in.op = OP_LOOKUP;
    endcase
  end

  assign s_tready = (cnt != 2'd2);
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (cnt != 2'd0);
  assign q_item   = fifo[rp];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wp] <= item_in;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (q_pop) begin
        rp <= ~rp;
      end
      cnt <= cnt + 2'(push) - 2'(q_pop);
    end
  end

endmodule

/* rtl/alt_back.sv */
// Back of the alarm table: entry memory and the sequencer that looks up,
// updates, evicts, summarizes and registers the result. Depends on alt_pkg.
module alt_back
  import alt_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int CODE_BITS   = DEF_CODE_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  item_t               q_item,
  output logic                q_pop,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OUT_BITS-1:0] m_tdata
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [IW-1:0] LAST  = IW'(TABLE_DEPTH - 1);
  localparam logic [CW-1:0] DEPTH = CW'(TABLE_DEPTH);

  typedef struct packed {
    logic [CODE_BITS-1:0] code;
    logic [2:0]           sev;
    lc_t                  lc;
    logic [31:0]          raised;
    logic [31:0]          acked;
    logic [31:0]          cleared;
    logic [31:0]          updated;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_ACT,
    S_SHIFT,
    S_SUM,
    S_OUT
  } state_t;

  state_t               state;
  item_t                cur;
  logic [CODE_BITS-1:0] code;
  logic [CW-1:0]        ra;
  logic                 pv;
  logic [IW-1:0]        pa;
  logic                 found;
  logic [IW-1:0]        midx;
  entry_t               ment;
  logic                 cf;
  logic [IW-1:0]        cidx;
  logic [31:0]          cclr;
  logic [31:0]          crse;
  logic [CW-1:0]        total;
  logic [31:0]          ovf;
  logic                 dirty;
  logic [2:0]           status;
  logic [IW-1:0]        sidx;
  logic [CW-1:0]        act_cnt;
  logic [2:0]           hi;
  result_t              res;

  entry_t               mem [TABLE_DEPTH];
  entry_t               rd;
  logic                 we;
  logic [IW-1:0]        wa;
  entry_t               wd;
  entry_t               new_ent;
  logic                 is_match;
  logic                 is_cand;
  logic [CODE_BITS+15:0] code_ext;
  logic [IW+4:0]        slot_ext;
  logic [CW+5:0]        act_ext;
  logic [CW+5:0]        tot_ext;

  // Key kept in its low CODE_BITS bits.
  assign code_ext = {{CODE_BITS{1'b0}}, q_item.code};

  // Entry memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd <= mem[ra[IW-1:0]];
  end

  // Fresh entry for a new or reactivated alarm.
  always_comb begin
    new_ent.code    = code;
    new_ent.sev     = cur.sev;
    new_ent.lc      = LC_ACTIVE;
    new_ent.raised  = cur.now;
    new_ent.acked   = '0;
    new_ent.cleared = '0;
    new_ent.updated = cur.now;
  end

  // Match and eviction candidate tests on the entry being read back.
  assign is_match = (rd.code == code);
  assign is_cand  = (rd.lc == LC_CLEARED) &&
                    (!cf || (rd.cleared < cclr) || ((rd.cleared == cclr) && (rd.raised < crse)));

  // Memory write selection.
  always_comb begin
    we = 1'b0;
    wa = pa;
    wd = rd;
    unique case (state)
      S_ACT: begin
        unique case (cur.op)
          OP_RAISE: begin
            if (found) begin
              we = 1'b1;
              wa = midx;
              if (ment.lc == LC_CLEARED) begin
                wd = new_ent;
              end else begin
                wd = ment;
                wd.updated = cur.now;
                if (cur.sev > ment.sev) begin
                  wd.sev = cur.sev;
                end
              end
            end else if (total < DEPTH) begin
              we = 1'b1;
              wa = total[IW-1:0];
              wd = new_ent;
            end else if (cf && (cidx == LAST)) begin
              we = 1'b1;
              wa = LAST;
              wd = new_ent;
            end
          end
          OP_CLEAR, OP_CLEAR_ACTIVE: begin
            if (found && !((cur.op == OP_CLEAR_ACTIVE) && (ment.lc == LC_CLEARED))) begin
              we         = 1'b1;
              wa         = midx;
              wd         = ment;
              wd.lc      = LC_CLEARED;
              wd.cleared = cur.now;
              wd.updated = cur.now;
            end
          end
          OP_ACK: begin
            if (found) begin
              we         = 1'b1;
              wa         = midx;
              wd         = ment;
              wd.lc      = LC_ACKED;
              wd.acked   = cur.now;
              wd.updated = cur.now;
            end
          end
          default: begin
            we = 1'b0;
          end
        endcase
      end
      S_SHIFT: begin
        if (pv) begin
          we = 1'b1;
          wa = pa - 1'b1;
          wd = rd;
        end else if (ra == DEPTH) begin
          we = 1'b1;
          wa = LAST;
          wd = new_ent;
        end
      end
      S_SUM: begin
        if (pv && (cur.op == OP_ACK_ALL) && (rd.lc == LC_ACTIVE)) begin
          we       = 1'b1;
          wd.lc    = LC_ACKED;
          wd.acked = cur.now;
        end
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  assign q_pop = (state == S_IDLE) && q_valid;

  // Result field extension to the fixed port widths.
  assign slot_ext = {5'b0, sidx};
  assign act_ext  = {6'b0, act_cnt};
  assign tot_ext  = {6'b0, total};

  // Sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      total    <= '0;
      ovf      <= '0;
      dirty    <= 1'b0;
      pv       <= 1'b0;
    end else begin
      pv <= 1'b0;
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur   <= q_item;
            code  <= code_ext[CODE_BITS-1:0];
            ra    <= '0;
            found <= 1'b0;
            cf    <= 1'b0;
            state <= S_SCAN;
          end
        end
        // Lookup and eviction candidate search over the held entries.
        S_SCAN: begin
          if (ra < total) begin
            pv <= 1'b1;
            pa <= ra[IW-1:0];
            ra <= ra + 1'b1;
          end
          if (pv) begin
            if (is_match && !found) begin
              found <= 1'b1;
              midx  <= pa;
              ment  <= rd;
            end
            if (is_cand) begin
              cf   <= 1'b1;
              cidx <= pa;
              cclr <= rd.cleared;
              crse <= rd.raised;
            end
          end else if (ra >= total) begin
            state <= S_ACT;
          end
        end
        // Decide the outcome; single-entry writes happen here.
        S_ACT: begin
          status  <= ST_APPLIED;
          sidx    <= '0;
          act_cnt <= '0;
          hi      <= '0;
          ra      <= '0;
          state   <= S_SUM;
          unique case (cur.op)
            OP_RAISE: begin
              if (found) begin
                sidx <= midx;
                if ((ment.lc == LC_CLEARED) || (cur.sev > ment.sev)) begin
                  status <= ST_REACTIVE;
                  dirty  <= 1'b1;
                end else begin
                  status <= ST_REFRESH;
                end
              end else if (total < DEPTH) begin
                status <= ST_NEW;
                sidx   <= total[IW-1:0];
                total  <= total + 1'b1;
                dirty  <= 1'b1;
              end else if (!cf) begin
                status <= ST_REJECTED;
                ovf    <= ovf + 1'b1;
              end else begin
                status <= ST_EVICTED;
                sidx   <= LAST;
                dirty  <= 1'b1;
                if (cidx != LAST) begin
                  ra    <= CW'(cidx) + 1'b1;
                  state <= S_SHIFT;
                end
              end
            end
            OP_ACK_ALL: begin
              dirty <= 1'b1;
            end
            default: begin
              if (!found) begin
                status <= ST_NOT_FOUND;
              end else begin
                sidx <= midx;
                if ((cur.op == OP_CLEAR_ACTIVE) && (ment.lc == LC_CLEARED)) begin
                  status <= ST_ALREADY;
                end else if ((cur.op == OP_CLEAR) || (cur.op == OP_CLEAR_ACTIVE) ||
                             (cur.op == OP_ACK)) begin
                  dirty <= 1'b1;
                end
              end
            end
          endcase
        end
        // Move the entries after the evicted one down by one slot, then write the new entry into the last slot.
        S_SHIFT: begin
          if (ra < DEPTH) begin
            pv <= 1'b1;
            pa <= ra[IW-1:0];
            ra <= ra + 1'b1;
          end else if (!pv) begin
            ra    <= '0;
            state <= S_SUM;
          end
        end
        // Active count and highest live severity; acknowledge-all writes back here.
        S_SUM: begin
          if (ra < total) begin
            pv <= 1'b1;
            pa <= ra[IW-1:0];
            ra <= ra + 1'b1;
          end
          if (pv) begin
            if (rd.lc != LC_CLEARED) begin
              act_cnt <= act_cnt + 1'b1;
              if (rd.sev > hi) begin
                hi <= rd.sev;
              end
            end
          end else if (ra >= total) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid             <= 1'b1;
            res.status           <= status;
            res.slot             <= slot_ext[4:0];
            res.active_count     <= act_ext[5:0];
            res.total_count      <= tot_ext[5:0];
            res.highest_severity <= hi;
            res.overflow_total   <= ovf;
            res.dirty            <= dirty;
            state                <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign m_tdata = res;

endmodule

/* rtl/alarm_lifecycle_table_top.sv */
// Channel  Dir  Payload (tdata, lowest bits first)
// s_*      in   action 3, alarm_code 16, severity 3, now_time 32, pad 2
// m_*      out  status 3, slot 5, active_count 6, total_count 6,
//               highest_severity 3, overflow_total 32, dirty 1
//
// One request is processed at a time; the single read port of the entry memory is
// scanned once for lookup and once for the summary, and a raise that evicts below
// the last slot also shifts the later entries down by one slot. Reset is synchronous
// and empties the table.
// A two-entry queue takes requests while the back works, and the result
// register lets the back finish while the output is stalled.
// Top level of the alarm table; depends on alt_pkg, alt_front and alt_back.
module alarm_lifecycle_table_top
  import alt_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int CODE_BITS   = DEF_CODE_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [IN_BITS-1:0]  s_tdata,  // action, alarm_code, severity, now_time
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OUT_BITS-1:0] m_tdata   // status, slot, active_count, total_count,
                                        // highest_severity, overflow_total, dirty
);

  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  // Request intake and classification.
  alt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  // Table storage and sequencing.
  alt_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .CODE_BITS   (CODE_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

/* rtl/alt_checker.sv */
// Port-level checks for the alarm table, bound to the top level.
// Depends on alt_pkg and alarm_lifecycle_table_top.
module alt_checker
  import alt_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic [IN_BITS-1:0]  s_tdata,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [OUT_BITS-1:0] m_tdata
);

  result_t r;
  assign r = m_tdata;

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // Active entries never outnumber held entries.
  a_counts: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> r.active_count <= r.total_count)
    else $error("active count above total count");

  // A rejected raise touches no slot and leaves the table full; checked as slot zero and a nonzero total count.
  a_reject: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && r.status == ST_REJECTED |-> r.slot == 5'd0 && r.total_count != 6'd0)
    else $error("rejected raise reports a slot");

  // No live entry means no live severity.
  a_sev: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && r.active_count == 6'd0 |-> r.highest_severity == 3'd0)
    else $error("severity reported with no active entry");

endmodule

bind alarm_lifecycle_table_top alt_checker u_chk (.*);
